// ===== rtl/srrmp_pkg.sv =====
`default_nettype none
package srrmp_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    word_t iv_word0;
    word_t iv_word1;
    word_t iv_word2;
    word_t iv_word3;
  } in_word_t;

  typedef struct packed {
    logic mid_parity;
    logic end_parity;
    logic parities_match;
  } out_word_t;

  localparam word_t Sigma0 = 32'h6170_7865;
  localparam word_t Sigma1 = 32'h3320_646e;
  localparam word_t Sigma2 = 32'h7962_2d32;
  localparam word_t Sigma3 = 32'h6b20_6574;

  localparam int unsigned NumKeys  = 8;
  localparam int unsigned KeyIdxW  = 3;
  // Eight rounds of four dependent additions each, one addition per stage.
  localparam int unsigned NumSteps = 32;
  // The mask is first sampled after the second addition of the eighth round.
  localparam int unsigned MidStep  = 29;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One addition-rotate-xor step applied to all four quarter-rounds of a round.
  // Step j belongs to round j/4 (even rounds are column rounds) and is sub-step j%4.
  function automatic state_t step_fn(state_t s, int unsigned j);
    state_t      r;
    logic [1:0]  sub;
    logic        is_row;
    logic [3:0]  a;
    logic [3:0]  b;
    logic [3:0]  c;
    logic [3:0]  d;
    r      = s;
    sub    = 2'(j & 3);
    is_row = 1'((j >> 2) & 1);
    for (int q = 0; q < 4; q++) begin
      a = 4'(5 * q);
      if (is_row) begin
        b = 4'(4 * q + ((q + 1) & 3));
        c = 4'(4 * q + ((q + 2) & 3));
        d = 4'(4 * q + ((q + 3) & 3));
      end else begin
        b = 4'(5 * q + 4);
        c = 4'(5 * q + 8);
        d = 4'(5 * q + 12);
      end
      case (sub)
        2'd0: r[b] = r[b] ^ rotl(r[a] + r[d], 7);
        2'd1: r[c] = r[c] ^ rotl(r[b] + r[a], 9);
        2'd2: r[d] = r[d] ^ rotl(r[c] + r[b], 13);
        default: r[a] = r[a] ^ rotl(r[d] + r[c], 18);
      endcase
    end
    return r;
  endfunction

  function automatic logic mask_parity(state_t s);
    return s[0][4] ^ s[0][0] ^ s[3][17] ^ s[5][22] ^ s[5][17] ^ s[4][7] ^
           s[10][24] ^ s[10][10] ^ s[10][5] ^ s[9][24] ^ s[15][17] ^
           s[15][7] ^ s[15][25] ^ s[15][24] ^ s[14][25] ^ s[14][7];
  endfunction

  // Carry approximation of one sum bit; i is always 2..31.
  function automatic logic approx_one(word_t x, word_t y, int unsigned i);
    return x[i] ^ y[i] ^ (x[i-1] & y[i-1]) ^ (x[i-1] & x[i-2] & y[i-2]) ^
           (y[i-1] & x[i-2] & y[i-2]);
  endfunction

  function automatic logic approx_two(word_t x, word_t y, int unsigned i);
    return x[i] ^ y[i] ^ x[i-1] ^ y[i-1] ^ (x[i-1] & y[i-1]) ^
           (x[i-2] & y[i-2]) ^ (x[i-1] & x[i-2] & y[i-2]) ^
           (y[i-1] & x[i-2] & y[i-2]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/srrmp_core.sv =====
`default_nettype none
// Round pipeline: one stage for each addition step, valid bits ride along,
// and a stage loads whenever it is empty or the stage after it moves.
module srrmp_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire srrmp_pkg::state_t in_state_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output srrmp_pkg::state_t     out_state_o,
  output logic                  out_mid_o
);

  localparam int unsigned N = srrmp_pkg::NumSteps;

  logic [N-1:0]      valid_q;
  logic [N-1:0]      mid_q;
  srrmp_pkg::state_t st_q [N];
  logic [N:0]        ready;

  always_comb begin
    ready[N] = !out_stall_i;
    for (int k = N - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_stall_o = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      st_q[0]  <= srrmp_pkg::step_fn(in_state_i, 0);
      mid_q[0] <= 1'b0;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_stage
    srrmp_pkg::state_t nxt;
    assign nxt = srrmp_pkg::step_fn(st_q[k-1], k);

    always_ff @(posedge clk_i) begin
      if (ready[k]) begin
        st_q[k] <= nxt;
        if (k == srrmp_pkg::MidStep) begin
          mid_q[k] <= srrmp_pkg::mask_parity(nxt);
        end else begin
          mid_q[k] <= mid_q[k-1];
        end
      end
    end
  end

  assign out_valid_o = valid_q[N-1];
  assign out_state_o = st_q[N-1];
  assign out_mid_o   = mid_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/salsa_reduced_round_mask_parity.sv =====
`default_nettype none
// Reduced-round Salsa20 mask-parity probe.
// Each input word carries four IV words; together with eight key registers and
// the four fixed constants they form a fresh 16-word state for one trial. The
// block runs seven rounds and the eighth row round, samples a fixed bit mask
// parity halfway through the eighth round and again at its end (with carry
// approximation terms folded in), and returns one output word per trial with
// both parities and whether they match.
// Channels use valid/stall: a word moves on a rising edge with valid high and
// stall low. Key registers are written through cfg_we_i/cfg_index_i/cfg_data_i
// and must only change while no trial is in flight.
// Throughput is one trial per cycle while the receiver does not stall. Each of
// the 32 pipeline stages performs one 32-bit add-rotate-xor across the four
// quarter-rounds, and one more register forms the parities.
// When the receiver stalls, the output register holds its word and the stall
// ripples back stage by stage; empty stages still fill, so the input only
// stalls once every stage holds a trial. Reset empties the pipeline and
// clears all key registers to zero.
module salsa_reduced_round_mask_parity (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire srrmp_pkg::in_word_t          in_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output srrmp_pkg::out_word_t              out_word_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [srrmp_pkg::KeyIdxW-1:0] cfg_index_i,
  input  wire srrmp_pkg::word_t             cfg_data_i
);

  srrmp_pkg::word_t     key_q [srrmp_pkg::NumKeys];
  srrmp_pkg::state_t    init_state;
  logic                 core_valid;
  logic                 core_stall;
  srrmp_pkg::state_t    fin;
  logic                 core_mid;
  logic                 end_par;
  logic                 out_ready;
  logic                 out_valid_q;
  srrmp_pkg::out_word_t out_word_q;

  // Key registers. Every index of the port names one of the eight keys.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < srrmp_pkg::NumKeys; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Initial state: constants on the diagonal, keys in words 1..4 and 11..14,
  // IV words in 6..9.
  always_comb begin
    init_state[0]  = srrmp_pkg::Sigma0;
    init_state[1]  = key_q[0];
    init_state[2]  = key_q[1];
    init_state[3]  = key_q[2];
    init_state[4]  = key_q[3];
    init_state[5]  = srrmp_pkg::Sigma1;
    init_state[6]  = in_word_i.iv_word0;
    init_state[7]  = in_word_i.iv_word1;
    init_state[8]  = in_word_i.iv_word2;
    init_state[9]  = in_word_i.iv_word3;
    init_state[10] = srrmp_pkg::Sigma2;
    init_state[11] = key_q[4];
    init_state[12] = key_q[5];
    init_state[13] = key_q[6];
    init_state[14] = key_q[7];
    init_state[15] = srrmp_pkg::Sigma3;
  end

  srrmp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_state_i  (init_state),
    .out_valid_o (core_valid),
    .out_stall_i (core_stall),
    .out_state_o (fin),
    .out_mid_o   (core_mid)
  );

  // Final mask parity plus the carry approximation terms on word pairs.
  assign end_par = srrmp_pkg::mask_parity(fin) ^
      srrmp_pkg::approx_one(fin[2], fin[3], 18) ^
      srrmp_pkg::approx_one(fin[2], fin[3], 14) ^
      srrmp_pkg::approx_one(fin[2], fin[1], 4) ^
      srrmp_pkg::approx_one(fin[4], fin[7], 31) ^
      srrmp_pkg::approx_one(fin[4], fin[7], 4) ^
      srrmp_pkg::approx_one(fin[6], fin[7], 26) ^
      srrmp_pkg::approx_one(fin[8], fin[9], 24) ^
      srrmp_pkg::approx_one(fin[8], fin[9], 19) ^
      srrmp_pkg::approx_one(fin[8], fin[9], 6) ^
      srrmp_pkg::approx_one(fin[8], fin[11], 11) ^
      srrmp_pkg::approx_one(fin[13], fin[14], 31) ^
      srrmp_pkg::approx_one(fin[13], fin[14], 21) ^
      srrmp_pkg::approx_two(fin[13], fin[14], 7) ^
      srrmp_pkg::approx_one(fin[12], fin[13], 26) ^
      srrmp_pkg::approx_one(fin[12], fin[13], 12);

  // Output register: loads whenever it is empty or its word is being taken.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign core_stall = !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_word_q.mid_parity     <= core_mid;
      out_word_q.end_parity     <= end_par;
      out_word_q.parities_match <= (core_mid == end_par);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire
